// ----- rtl/core/sshh_pkg.sv -----
// Shared types, command codes and helpers for the frequent-item table core.
// No dependencies; used by sshh_front, sshh_back and the top level.
package sshh_pkg;

  // Command codes carried on the command input
  localparam logic [1:0] OP_UPDATE   = 2'd0;
  localparam logic [1:0] OP_ESTIMATE = 2'd1;
  localparam logic [1:0] OP_REPORT   = 2'd2;

  // Report length limit and the width of a counter that holds it
  localparam int MAX_RESULTS = 16;
  localparam int RES_CW      = $clog2(MAX_RESULTS + 1);

  // One queued item after classification
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] item_key;
    logic [15:0] weight;
    logic [15:0] error_increment;
    logic [31:0] threshold;
  } cmd_t;

  // Saturating add of a 16-bit increment to a 32-bit total
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ----- rtl/core/sshh_front.sv -----
// Front end: accepts items, drops those with no effect, queues the rest.
// Depends on sshh_pkg.
module sshh_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic [31:0]        item_key,
  input  logic [15:0]        weight,
  input  logic [15:0]        error_increment,
  input  logic [31:0]        threshold,
  output logic               q_valid,
  output sshh_pkg::cmd_t     q_head,
  input  logic               q_pop
);

  sshh_pkg::cmd_t entry [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           accept;
  logic           keep;
  logic           push;

  assign busy    = (count == 2'd2);
  assign accept  = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_head  = entry[rd_ptr];

  // Classify: zero-weight updates and unknown codes need no work
  assign keep = ((command == sshh_pkg::OP_UPDATE) && (weight != 16'd0)) ||
                (command == sshh_pkg::OP_ESTIMATE) ||
                (command == sshh_pkg::OP_REPORT);
  assign push = accept && keep;

  // Store the queued item
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= '{op: command, item_key: item_key, weight: weight,
                         error_increment: error_increment, threshold: threshold};
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ----- rtl/core/sshh_back.sv -----
// Back end: slot table memory, scan engine for match, minimum and report order.
// Depends on sshh_pkg.
module sshh_back #(
  parameter int SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  sshh_pkg::cmd_t     q_head,
  output logic               q_pop,
  output logic               strobe,
  output logic [31:0]        result_item,
  output logic [31:0]        result_count,
  output logic [31:0]        result_error,
  output logic               held,
  output logic               last
);

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_EST   = 3'd3;
  localparam logic [2:0] S_RSTEP = 3'd4;
  localparam logic [2:0] S_RFIN  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [31:0] mem_key   [SLOTS];
  logic [31:0] mem_count [SLOTS];
  logic [31:0] mem_error [SLOTS];
  logic [SLOTS-1:0] occ;

  logic [2:0]    state;
  logic [IW-1:0] idx;
  logic          iss;
  logic          rd_v;
  logic [IW-1:0] rd_i;
  logic [31:0]   rd_key, rd_count, rd_error;
  logic          rd_occ;
  logic [31:0]   e_key, e_count, e_error;

  logic          match_f;
  logic [IW-1:0] match_i;
  logic [31:0]   match_count, match_error;
  logic [IW-1:0] min_i;
  logic [31:0]   min_count;

  logic          best_f;
  logic [IW-1:0] best_i;
  logic [31:0]   best_key, best_count, best_error;
  logic          best_occ;
  logic          prev_v;
  logic [IW-1:0] prev_i;
  logic [31:0]   prev_count;
  logic          pend_v;
  logic [31:0]   pend_key, pend_count, pend_error;
  logic          pend_occ;
  logic [sshh_pkg::RES_CW-1:0] sent;

  logic          cand;
  logic          wr_en;
  logic [IW-1:0] wr_i;
  logic [31:0]   wr_count, wr_error;

  // Mask free slots to their reset value
  assign e_key   = rd_occ ? rd_key   : 32'd0;
  assign e_count = rd_occ ? rd_count : 32'd0;
  assign e_error = rd_occ ? rd_error : 32'd0;

  // Report candidate: meets threshold and follows the previous pick in order
  assign cand = (e_count >= q_head.threshold) &&
                (!prev_v || (e_count > prev_count) ||
                 ((e_count == prev_count) && (rd_i > prev_i)));

  // Update target and new totals
  assign wr_en    = (state == S_WRITE);
  assign wr_i     = match_f ? match_i : min_i;
  assign wr_count = sshh_pkg::sat_add(match_f ? match_count : min_count, q_head.weight);
  assign wr_error = sshh_pkg::sat_add(match_f ? match_error : min_count,
                                      q_head.error_increment);
  assign q_pop    = (state == S_DONE);

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_i]   <= q_head.item_key;
      mem_count[wr_i] <= wr_count;
      mem_error[wr_i] <= wr_error;
    end
    if (iss) begin
      rd_key   <= mem_key[idx];
      rd_count <= mem_count[idx];
      rd_error <= mem_error[idx];
      rd_occ   <= occ[idx];
    end
    rd_i <= idx;
  end

  // Occupied flags
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (wr_en) begin
      occ[wr_i] <= 1'b1;
    end
  end

  // Sequencer and scan bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      iss    <= 1'b0;
      rd_v   <= 1'b0;
      idx    <= '0;
      strobe <= 1'b0;
      pend_v <= 1'b0;
      prev_v <= 1'b0;
      sent   <= '0;
    end else begin
      strobe <= 1'b0;
      rd_v   <= iss;
      if (iss) begin
        idx <= idx + IW'(1);
        if (idx == LAST_IDX) iss <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            idx     <= '0;
            iss     <= 1'b1;
            match_f <= 1'b0;
            best_f  <= 1'b0;
            prev_v  <= 1'b0;
            pend_v  <= 1'b0;
            sent    <= '0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_v) begin
            // Track first match and first least count
            if (!match_f && rd_occ && (rd_key == q_head.item_key)) begin
              match_f     <= 1'b1;
              match_i     <= rd_i;
              match_count <= rd_count;
              match_error <= rd_error;
            end
            if ((rd_i == '0) || (e_count < min_count)) begin
              min_i     <= rd_i;
              min_count <= e_count;
            end
            // Track least qualifying slot for the report pass
            if (cand && (!best_f || (e_count < best_count))) begin
              best_f     <= 1'b1;
              best_i     <= rd_i;
              best_key   <= e_key;
              best_count <= e_count;
              best_error <= e_error;
              best_occ   <= rd_occ;
            end
            if (rd_i == LAST_IDX) begin
              case (q_head.op)
                sshh_pkg::OP_UPDATE:   state <= S_WRITE;
                sshh_pkg::OP_ESTIMATE: state <= S_EST;
                default:               state <= S_RSTEP;
              endcase
            end
          end
        end
        S_WRITE: begin
          state <= S_DONE;
        end
        S_EST: begin
          strobe       <= 1'b1;
          result_item  <= q_head.item_key;
          result_count <= match_f ? match_count : min_count;
          result_error <= 32'd0;
          held         <= match_f;
          last         <= 1'b1;
          state        <= S_DONE;
        end
        S_RSTEP: begin
          if (best_f) begin
            // Emit the held pick, hold the new one until the next is known
            if (pend_v) begin
              strobe       <= 1'b1;
              result_item  <= pend_key;
              result_count <= pend_count;
              result_error <= pend_error;
              held         <= pend_occ;
              last         <= 1'b0;
            end
            pend_v     <= 1'b1;
            pend_key   <= best_key;
            pend_count <= best_count;
            pend_error <= best_error;
            pend_occ   <= best_occ;
            sent       <= sent + sshh_pkg::RES_CW'(pend_v);
            if ((32'(sent) + 32'(pend_v) + 32'd1) >= 32'(sshh_pkg::MAX_RESULTS)) begin
              state <= S_RFIN;
            end else begin
              prev_v     <= 1'b1;
              prev_i     <= best_i;
              prev_count <= best_count;
              best_f     <= 1'b0;
              idx        <= '0;
              iss        <= 1'b1;
              state      <= S_SCAN;
            end
          end else begin
            state <= pend_v ? S_RFIN : S_DONE;
          end
        end
        S_RFIN: begin
          strobe       <= 1'b1;
          result_item  <= pend_key;
          result_count <= pend_count;
          result_error <= pend_error;
          held         <= pend_occ;
          last         <= 1'b1;
          state        <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // A table write only follows a finished scan
  a_write_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> $past(state == S_SCAN))
    else $error("slot write without a preceding scan");

  // Occupied slots never become free
  a_occ_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (($past(occ) & ~occ) == '0))
    else $error("occupied flag cleared");

  // No read data is pending while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!rd_v && !iss))
    else $error("scan activity while idle");

  // Report never exceeds its length limit
  a_sent_limit: assert property (@(posedge clk) disable iff (rst)
    32'(sent) < 32'(sshh_pkg::MAX_RESULTS))
    else $error("report length exceeded");
`endif

endmodule

// ----- rtl/core/space_saving_heavy_hitters_core.sv -----
// Top level of the frequent-item table: front queue plus back scan engine.
// Depends on sshh_pkg, sshh_front and sshh_back.
//
// Items are taken when start is high and busy is low; busy rises only when the
// two-entry command queue is full. Each queued item is carried out by one scan
// engine that reads the slot memory one slot per cycle: an update or an estimate
// takes one full slot scan, and a report repeats the scan for each result until
// none is left or the length limit is reached. Zero-weight updates and unknown
// commands are dropped at the front. Results appear on the result ports for a
// single cycle with strobe high and must be taken then; there is no way to hold
// them off.
module space_saving_heavy_hitters_core #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [31:0] item_key,
  input  logic [15:0] weight,
  input  logic [15:0] error_increment,
  input  logic [31:0] threshold,
  output logic        strobe,
  output logic [31:0] result_item,
  output logic [31:0] result_count,
  output logic [31:0] result_error,
  output logic        held,
  output logic        last
);

  logic           q_valid;
  logic           q_pop;
  sshh_pkg::cmd_t q_head;

  // Accept and classify
  sshh_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .item_key(item_key), .weight(weight),
    .error_increment(error_increment), .threshold(threshold),
    .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop)
  );

  // Execute against the slot table
  sshh_back #(.SLOTS(SLOTS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .strobe(strobe), .result_item(result_item), .result_count(result_count),
    .result_error(result_error), .held(held), .last(last)
  );

endmodule
